// ===== rtl/crc16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_pkg
// Shared types and bit-manipulation functions for the configurable CRC-16
// engine.
// ----------------------------------------------------------------------------
package crc16_pkg;

  localparam int CrcW  = 16;
  localparam int ByteW = 8;

  // Register map, index order (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_POLYNOMIAL     = 3'd0,
    REG_INITIAL_VALUE  = 3'd1,
    REG_FINAL_XOR      = 3'd2,
    REG_REFLECT_INPUT  = 3'd3,
    REG_REFLECT_OUTPUT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CrcW-1:0] polynomial;
    logic [CrcW-1:0] initial_value;
    logic [CrcW-1:0] final_xor;
    logic            reflect_input;
    logic            reflect_output;
  } cfg_t;

  // Pipeline status seen by the top level
  typedef struct packed {
    logic s1_valid;
    logic s1_last;
    logic out_valid;
  } core_stat_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

  function automatic logic [CrcW-1:0] rev16(input logic [CrcW-1:0] w);
    return {rev8(w[7:0]), rev8(w[15:8])};
  endfunction

  // Fold one byte into the remainder, MSB first, eight shift/XOR steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0]  rem,
                                               input logic [ByteW-1:0] data,
                                               input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] r;
    r = rem ^ {data, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (r[CrcW-1]) begin
        r = {r[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crc16_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_regs
// APB configuration registers: polynomial, seed, final XOR, reflections.
// ----------------------------------------------------------------------------
module crc16_regs (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  output crc16_pkg::cfg_t             cfg
);
  import crc16_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polynomial     <= 16'h1021;
      cfg.initial_value  <= 16'hFFFF;
      cfg.final_xor      <= 16'h0000;
      cfg.reflect_input  <= 1'b0;
      cfg.reflect_output <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_POLYNOMIAL:     cfg.polynomial     <= pwdata[15:0];
        REG_INITIAL_VALUE:  cfg.initial_value  <= pwdata[15:0];
        REG_FINAL_XOR:      cfg.final_xor      <= pwdata[15:0];
        REG_REFLECT_INPUT:  cfg.reflect_input  <= pwdata[0];
        REG_REFLECT_OUTPUT: cfg.reflect_output <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLYNOMIAL:     prdata = {16'h0000, cfg.polynomial};
      REG_INITIAL_VALUE:  prdata = {16'h0000, cfg.initial_value};
      REG_FINAL_XOR:      prdata = {16'h0000, cfg.final_xor};
      REG_REFLECT_INPUT:  prdata = {31'd0, cfg.reflect_input};
      REG_REFLECT_OUTPUT: prdata = {31'd0, cfg.reflect_output};
      default:            prdata = 32'h0000_0000;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/crc16_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_core
// Input register, combinational seed/fold/finalize logic, running remainder and
// result register.
// ----------------------------------------------------------------------------
module crc16_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire crc16_pkg::cfg_t       cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data,
  input  wire logic                  in_first,
  input  wire logic                  in_last,
  input  wire logic [15:0]           in_resume,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                out_crc,
  output crc16_pkg::core_stat_t      stat
);
  import crc16_pkg::*;

  // input stage
  logic             s1_valid;
  logic [ByteW-1:0] s1_data;
  logic             s1_first;
  logic             s1_last;
  logic [CrcW-1:0]  s1_resume;

  logic [CrcW-1:0]  rem;
  logic [CrcW-1:0]  seed;
  logic [CrcW-1:0]  undone;
  logic [ByteW-1:0] data_in;
  logic [CrcW-1:0]  rem_next;
  logic [CrcW-1:0]  crc_next;
  logic             s1_adv;

  // a last byte may only leave stage 1 when the result register has room
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_comb begin
    undone = s1_resume ^ cfg.final_xor;
    if (s1_first) begin
      if (s1_resume != '0) begin
        seed = cfg.reflect_output ? rev16(undone) : undone;
      end else begin
        seed = cfg.initial_value;
      end
    end else begin
      seed = rem;
    end
    data_in  = cfg.reflect_input ? rev8(s1_data) : s1_data;
    rem_next = crc_byte(seed, data_in, cfg.polynomial);
    crc_next = (cfg.reflect_output ? rev16(rem_next) : rem_next) ^ cfg.final_xor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      rem       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
      end
      if (s1_adv) begin
        rem <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data   <= in_data;
      s1_first  <= in_first;
      s1_last   <= in_last;
      s1_resume <= in_resume;
    end
    if (s1_adv && s1_last) begin
      out_crc <= crc_next;
    end
  end

  assign stat.s1_valid  = s1_valid;
  assign stat.s1_last   = s1_last;
  assign stat.out_valid = out_valid;

endmodule
`default_nettype wire

// ===== rtl/configurable_crc16_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// configurable_crc16_engine
// Table-free MSB-first CRC-16 over a byte stream, APB-configurable.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Carries
// s_axis    in   s_tvalid/s_tready     message byte, resume CRC, first, last
// m_axis    out  m_tvalid/m_tready     finished CRC, one per last byte
// apb       in   psel/penable/pready   register writes and reads
//
// One byte per cycle sustained unless a last byte waits behind an untaken result.
// A byte is held in the input register; the CRC of a last byte then goes to the
// result register. The running remainder feeds back combinationally (seed, 8 folds).
// rst clears the remainder and both valid flags and loads register defaults.
// A stalled result blocks only once another last byte waits behind it.
// ----------------------------------------------------------------------------
module configurable_crc16_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] resume_crc
  input  wire logic        s_tuser,   // [0] first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] crc_value
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import crc16_pkg::*;

  cfg_t       cfg;
  core_stat_t stat;

  crc16_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crc16_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[7:0]),
    .in_first  (s_tuser),
    .in_last   (s_tlast),
    .in_resume (s_tdata[23:8]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_crc   (m_tdata),
    .stat      (stat)
  );

  // backpressure only from a last byte stuck behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (stat.s1_valid && stat.s1_last && m_tvalid && !m_tready))
    else $error("input stalled without a pending result");

  // a new result only follows a last byte leaving the input register
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.s1_valid && stat.s1_last))
    else $error("result produced without a last byte");

  a_poly_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[4:2] == REG_POLYNOMIAL)
    |=> cfg.polynomial == $past(pwdata[15:0]))
    else $error("polynomial register not updated");

endmodule
`default_nettype wire
